// ===== rtl/core/spf_pkg.sv =====
// Shared constants, types and the selectivity compare for the peak finder.
`timescale 1ns / 1ps
`default_nettype none
package spf_pkg;

    localparam int MAX_SAMPLES = 128;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_RESULTS = 64;

    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int LEN_W = $clog2(MAX_SAMPLES + 3);
    localparam int PK_W  = $clog2(MAX_RESULTS + 1);
    localparam int ENT_W = SAMPLE_BITS + IDX_W;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_INCLUDE_ENDPOINTS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FIND_MINIMA       = CFG_IDX_W'(1);

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;
    typedef logic [SAMPLE_BITS:0]          t_range;

    localparam t_smp SMP_MAX = t_smp'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    localparam t_smp SMP_MIN = t_smp'({1'b1, {(SAMPLE_BITS-1){1'b0}}});

    // One loaded frame, handed from the loader to the walker.
    typedef struct packed {
        logic             valid;
        logic             incl;
        t_smp             first;
        t_smp             last_val;
        logic [CNT_W-1:0] n_smp;
        logic [CNT_W-1:0] n_ext;
        t_smp             ext_min;
        t_smp             fmin;
        t_smp             fmax;
    } t_frame;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             valid;
        logic             last;
    } t_result;

    // True when a exceeds b by more than a quarter of the range, evaluated exactly.
    function automatic logic gt_sel(input t_smp a, input t_smp b, input t_range rng);
        logic signed [SAMPLE_BITS+3:0] lhs;
        logic signed [SAMPLE_BITS+3:0] rhs;
        lhs = {{2{a[SAMPLE_BITS-1]}}, a, 2'b00};
        rhs = $signed({{2{b[SAMPLE_BITS-1]}}, b, 2'b00}) + $signed({3'b000, rng});
        return lhs > rhs;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/spf_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module spf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/spf_front.sv =====
// Sample loader: tracks frame statistics and stores slope-sign changes as extrema.
`timescale 1ns / 1ps
`default_nettype none
module spf_front
    import spf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_smp             i_sample,
    input  wire logic             i_last,
    input  wire logic             i_find_minima,
    input  wire logic             i_incl,
    input  wire logic             i_done,
    output logic                  o_wr_en,
    output logic [IDX_W-1:0]      o_wr_addr,
    output logic [ENT_W-1:0]      o_wr_data,
    output t_frame                o_frame
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_ecnt, n_ecnt;
    t_smp             r_prev, n_prev;
    logic             r_pfall, n_pfall;
    t_smp             r_first, n_first;
    t_smp             r_fmin, n_fmin;
    t_smp             r_fmax, n_fmax;
    t_smp             r_exmin, n_exmin;
    t_frame           r_frame;

    logic acc;
    logic take;
    logic falling;
    logic store;
    t_smp v;

    always_comb begin
        acc     = i_valid && !r_frame.valid;
        take    = acc && (r_cnt < CNT_W'(MAX_SAMPLES));
        v       = i_sample;
        if (i_find_minima) begin
            v = (i_sample == SMP_MIN) ? SMP_MAX : -i_sample;
        end
        falling = (v <= r_prev);
        store   = take && (r_cnt >= CNT_W'(2)) && (falling != r_pfall)
                  && (r_ecnt < CNT_W'(MAX_SAMPLES));

        n_cnt   = r_cnt;
        n_ecnt  = r_ecnt;
        n_prev  = r_prev;
        n_pfall = r_pfall;
        n_first = r_first;
        n_fmin  = r_fmin;
        n_fmax  = r_fmax;
        n_exmin = r_exmin;
        if (take) begin
            if (i_sample < r_fmin) begin
                n_fmin = i_sample;
            end
            if (i_sample > r_fmax) begin
                n_fmax = i_sample;
            end
            if (r_cnt == '0) begin
                n_first = v;
            end else begin
                n_pfall = falling;
            end
            if (store) begin
                n_ecnt = r_ecnt + 1'b1;
                if (r_prev < r_exmin) begin
                    n_exmin = r_prev;
                end
            end
            n_prev = v;
            n_cnt  = r_cnt + 1'b1;
        end
    end

    assign o_ready   = !r_frame.valid;
    assign o_wr_en   = store;
    assign o_wr_addr = r_ecnt[IDX_W-1:0];
    assign o_wr_data = {r_prev, IDX_W'(r_cnt - 1'b1)};
    assign o_frame   = r_frame;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_ecnt        <= '0;
            r_prev        <= '0;
            r_pfall       <= 1'b0;
            r_first       <= '0;
            r_fmin        <= SMP_MAX;
            r_fmax        <= SMP_MIN;
            r_exmin       <= SMP_MAX;
            r_frame       <= '0;
        end else if (acc && i_last) begin
            r_frame <= '{valid: 1'b1, incl: i_incl, first: n_first, last_val: n_prev,
                         n_smp: n_cnt, n_ext: n_ecnt, ext_min: n_exmin,
                         fmin: n_fmin, fmax: n_fmax};
            r_cnt   <= '0;
            r_ecnt  <= '0;
            r_prev  <= '0;
            r_pfall <= 1'b0;
            r_first <= '0;
            r_fmin  <= SMP_MAX;
            r_fmax  <= SMP_MIN;
            r_exmin <= SMP_MAX;
        end else begin
            r_cnt   <= n_cnt;
            r_ecnt  <= n_ecnt;
            r_prev  <= n_prev;
            r_pfall <= n_pfall;
            r_first <= n_first;
            r_fmin  <= n_fmin;
            r_fmax  <= n_fmax;
            r_exmin <= n_exmin;
            if (i_done) begin
                r_frame.valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/spf_walk.sv =====
// Extremum walker: steps through the stored extrema of a frame and emits peak positions.
`timescale 1ns / 1ps
`default_nettype none
module spf_walk
    import spf_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_frame           i_frame,
    output logic                  o_done,
    output logic                  o_rd_en,
    output logic [IDX_W-1:0]      o_rd_addr,
    input  wire logic [ENT_W-1:0] i_rd_data,
    output logic                  o_push,
    output t_result               o_res,
    input  wire logic             i_res_ready
);

    typedef enum logic [3:0] {
        W_IDLE = 4'b0001,
        W_RD   = 4'b0010,
        W_EX   = 4'b0100,
        W_FIN  = 4'b1000
    } t_state;

    typedef enum logic [5:0] {
        PH_PRE0 = 6'b000001,
        PH_PRE1 = 6'b000010,
        PH_PRE2 = 6'b000100,
        PH_A    = 6'b001000,
        PH_B    = 6'b010000,
        PH_TAIL = 6'b100000
    } t_phase;

    typedef enum logic [1:0] {
        SRC_RAM, SRC_FIRST, SRC_LAST
    } t_src;

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    t_src             r_src, n_src;
    logic [LEN_W-1:0] r_j, n_j;
    logic [LEN_W-1:0] r_vlen, n_vlen;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_incl, n_incl;
    t_smp             r_first, n_first;
    t_smp             r_lastv, n_lastv;
    logic [IDX_W-1:0] r_lastpos, n_lastpos;
    t_smp             r_minmag, n_minmag;
    t_range           r_range, n_range;
    t_smp             r_v0, n_v0;
    t_smp             r_v1, n_v1;
    logic             r_drop, n_drop;
    logic             r_at, n_at;
    t_smp             r_lmin, n_lmin;
    t_smp             r_tmag, n_tmag;
    logic [IDX_W-1:0] r_tpos, n_tpos;
    logic             r_found, n_found;
    logic             r_cand, n_cand;
    logic [IDX_W-1:0] r_pend, n_pend;
    logic             r_hpend, n_hpend;
    logic [PK_W-1:0]  r_npk, n_npk;

    logic [LEN_W-1:0] k;
    logic [LEN_W-1:0] addr_full;
    t_smp             x;
    logic [IDX_W-1:0] p;
    logic             add;
    logic [IDX_W-1:0] add_pos;
    logic             up1, dn1, up2, dn2, drop, at;
    t_smp             w0, w1, tm, mm, min_aux;
    t_smp             ram_val;
    logic [IDX_W-1:0] ram_pos;

    assign ram_val = t_smp'(i_rd_data[ENT_W-1:IDX_W]);
    assign ram_pos = i_rd_data[IDX_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_src     = r_src;
        n_j       = r_j;
        n_vlen    = r_vlen;
        n_len     = r_len;
        n_incl    = r_incl;
        n_first   = r_first;
        n_lastv   = r_lastv;
        n_lastpos = r_lastpos;
        n_minmag  = r_minmag;
        n_range   = r_range;
        n_v0      = r_v0;
        n_v1      = r_v1;
        n_drop    = r_drop;
        n_at      = r_at;
        n_lmin    = r_lmin;
        n_tmag    = r_tmag;
        n_tpos    = r_tpos;
        n_found   = r_found;
        n_cand    = r_cand;
        n_pend    = r_pend;
        n_hpend   = r_hpend;
        n_npk     = r_npk;
        o_done    = 1'b0;
        o_rd_en   = 1'b0;
        o_push    = 1'b0;
        o_res     = '0;
        add       = 1'b0;
        add_pos   = '0;
        up1 = 1'b0; dn1 = 1'b0; up2 = 1'b0; dn2 = 1'b0; drop = 1'b0; at = 1'b0;
        w0 = r_v0; w1 = r_v1; tm = r_tmag; mm = '0; min_aux = '0;

        // Walk-list position to virtual position, skipping a dropped endpoint entry.
        k = r_j;
        if ((r_phase == PH_A || r_phase == PH_B || r_phase == PH_TAIL) && r_drop
            && (r_j >= LEN_W'(r_at))) begin
            k = r_j + 1'b1;
        end
        addr_full = k - LEN_W'(r_incl);
        o_rd_addr = addr_full[IDX_W-1:0];

        unique case (r_src)
            SRC_FIRST: begin x = r_first; p = '0;        end
            SRC_LAST:  begin x = r_lastv; p = r_lastpos; end
            default:   begin x = ram_val; p = ram_pos;   end
        endcase

        unique case (r_state)
            W_IDLE: begin
                if (i_frame.valid) begin
                    n_incl    = i_frame.incl;
                    n_first   = i_frame.first;
                    n_lastv   = i_frame.last_val;
                    n_lastpos = IDX_W'(i_frame.n_smp - 1'b1);
                    n_range   = t_range'({i_frame.fmax[SAMPLE_BITS-1], i_frame.fmax}
                                - {i_frame.fmin[SAMPLE_BITS-1], i_frame.fmin});
                    mm = i_frame.ext_min;
                    if (i_frame.incl) begin
                        if (i_frame.first < mm) begin
                            mm = i_frame.first;
                        end
                        if (i_frame.last_val < mm) begin
                            mm = i_frame.last_val;
                        end
                    end
                    n_minmag = mm;
                    n_vlen   = LEN_W'(i_frame.n_ext) + (i_frame.incl ? LEN_W'(2) : '0);
                    n_hpend  = 1'b0;
                    n_npk    = '0;
                    n_j      = '0;
                    n_phase  = PH_PRE0;
                    n_state  = (n_vlen <= LEN_W'(2)) ? W_FIN : W_RD;
                end
            end
            W_RD: begin
                o_rd_en = 1'b1;
                if (r_incl && k == '0) begin
                    n_src = SRC_FIRST;
                end else if (r_incl && k == r_vlen - 1'b1) begin
                    n_src = SRC_LAST;
                end else begin
                    n_src = SRC_RAM;
                end
                n_state = W_EX;
            end
            W_EX: begin
                if (i_res_ready) begin
                    n_state = W_RD;
                    unique case (r_phase)
                        PH_PRE0: begin
                            n_v0 = x; n_j = LEN_W'(1); n_phase = PH_PRE1;
                        end
                        PH_PRE1: begin
                            n_v1 = x; n_j = LEN_W'(2); n_phase = PH_PRE2;
                        end
                        PH_PRE2: begin
                            up1  = r_v1 > r_v0;
                            dn1  = r_v1 < r_v0;
                            up2  = x > r_v1;
                            dn2  = x < r_v1;
                            drop = r_incl && (up1 == up2) && (dn1 == dn2);
                            at   = !up1;
                            if (drop) begin
                                w0 = at ? r_v0 : r_v1;
                                w1 = x;
                            end
                            n_drop = drop;
                            n_at   = at;
                            n_len  = drop ? r_vlen - 1'b1 : r_vlen;
                            n_j    = (w0 >= w1) ? LEN_W'(0) : LEN_W'(1);
                            if (r_incl) begin
                                n_lmin = r_minmag;
                            end else begin
                                n_lmin = (r_v0 < r_first) ? r_v0 : r_first;
                            end
                            n_tmag  = r_minmag;
                            n_found = 1'b0;
                            n_cand  = 1'b0;
                            n_phase = PH_A;
                        end
                        PH_A: begin
                            tm      = r_found ? r_minmag : r_tmag;
                            n_found = 1'b0;
                            n_tmag  = tm;
                            if (x > tm && gt_sel(x, r_lmin, r_range)) begin
                                n_tmag = x;
                                n_tpos = p;
                                n_cand = 1'b1;
                            end
                            if (r_j + 1'b1 == r_len) begin
                                n_j = r_len - 1'b1; n_phase = PH_TAIL;
                            end else begin
                                n_j = r_j + 1'b1; n_phase = PH_B;
                            end
                        end
                        PH_B: begin
                            if (!r_found && gt_sel(r_tmag, x, r_range)) begin
                                n_found = 1'b1;
                                n_lmin  = x;
                                add     = 1'b1;
                                add_pos = r_tpos;
                            end else if (x < r_lmin) begin
                                n_lmin = x;
                            end
                            if (r_j + 1'b1 == r_len) begin
                                n_j = r_len - 1'b1; n_phase = PH_TAIL;
                            end else begin
                                n_j = r_j + 1'b1; n_phase = PH_A;
                            end
                        end
                        default: begin
                            // Tail check on the final walk entry.
                            n_state = W_FIN;
                            min_aux = (r_lastv < x) ? r_lastv : x;
                            if (r_incl) begin
                                if (x > r_tmag && gt_sel(x, r_lmin, r_range)) begin
                                    add = 1'b1; add_pos = p;
                                end else if (!r_found && r_tmag > r_minmag && r_cand) begin
                                    add = 1'b1; add_pos = r_tpos;
                                end
                            end else if (!r_found) begin
                                if (x > r_tmag && gt_sel(x, r_lmin, r_range)) begin
                                    add = 1'b1; add_pos = p;
                                end else if (r_cand && gt_sel(r_tmag, min_aux, r_range)) begin
                                    add = 1'b1; add_pos = r_tpos;
                                end
                            end
                        end
                    endcase
                    // The newest peak is held back so that the final one can carry the last flag.
                    if (add && r_npk < PK_W'(MAX_RESULTS)) begin
                        if (r_hpend) begin
                            o_push = 1'b1;
                            o_res  = '{index: r_pend, valid: 1'b1, last: 1'b0};
                        end
                        n_pend  = add_pos;
                        n_hpend = 1'b1;
                        n_npk   = r_npk + 1'b1;
                    end
                end
            end
            default: begin
                if (i_res_ready) begin
                    o_push  = 1'b1;
                    o_res   = '{index: r_hpend ? r_pend : '0, valid: r_hpend, last: 1'b1};
                    o_done  = 1'b1;
                    n_state = W_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= W_IDLE;
            r_phase <= PH_PRE0;
            r_src   <= SRC_RAM;
            r_hpend <= 1'b0;
            r_npk   <= '0;
            r_found <= 1'b0;
            r_cand  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_src   <= n_src;
            r_hpend <= n_hpend;
            r_npk   <= n_npk;
            r_found <= n_found;
            r_cand  <= n_cand;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j       <= n_j;
        r_vlen    <= n_vlen;
        r_len     <= n_len;
        r_incl    <= n_incl;
        r_first   <= n_first;
        r_lastv   <= n_lastv;
        r_lastpos <= n_lastpos;
        r_minmag  <= n_minmag;
        r_range   <= n_range;
        r_v0      <= n_v0;
        r_v1      <= n_v1;
        r_drop    <= n_drop;
        r_at      <= n_at;
        r_lmin    <= n_lmin;
        r_tmag    <= n_tmag;
        r_tpos    <= n_tpos;
        r_pend    <= n_pend;
    end

endmodule
`default_nettype wire

// ===== rtl/core/spf_resq.sv =====
// Small result queue between the walker and the output channel.
`timescale 1ns / 1ps
`default_nettype none
module spf_resq
    import spf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_ready,
    output logic         o_valid,
    output t_result      o_res,
    input  wire logic    i_pop_ready
);

    t_result          r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wp;
    logic [RQ_AW-1:0] r_rp;
    logic [RQ_AW:0]   r_cnt;
    logic             pop;
    logic             push;

    assign o_ready = (r_cnt != (RQ_AW+1)'(RQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rp];
    assign pop     = o_valid && i_pop_ready;
    assign push    = i_push && o_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (RQ_AW+1)'(push) - (RQ_AW+1)'(pop);
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/selective_peak_finder.sv =====
// Top level of the selectivity-based peak finder.
//
//  Channel   Direction  Handshake                    Payload
//  input     in         i_in_valid / o_in_ready      i_sample, i_last
//  result    out        o_out_valid / i_out_ready    o_peak_index, o_peak_valid, o_last_result
//  config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// The loader accepts samples back to back while its input is open. The last sample hands
// the frame to the walker, which reads each walk entry and then evaluates it, the RAM read
// port setting the pace. The input is held off from the last sample until the walk has
// ended; results wait in a four-entry queue, and a full queue stalls the walk. Reset is
// synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module selective_peak_finder
    import spf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                 i_last,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [IDX_W-1:0]          o_peak_index,
    output logic                      o_peak_valid,
    output logic                      o_last_result,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic                 i_cfg_data
);

    logic             r_incl;
    logic             r_fmin;
    t_frame           w_frame;
    logic             w_done;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [ENT_W-1:0] w_wr_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic [ENT_W-1:0] w_rd_data;
    logic             w_push;
    t_result          w_res;
    logic             w_q_ready;
    t_result          w_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_incl <= 1'b0;
            r_fmin <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_INCLUDE_ENDPOINTS: r_incl <= i_cfg_data;
                CFG_FIND_MINIMA:       r_fmin <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .o_ready       (o_in_ready),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .i_find_minima (r_fmin),
        .i_incl        (r_incl),
        .i_done        (w_done),
        .o_wr_en       (w_wr_en),
        .o_wr_addr     (w_wr_addr),
        .o_wr_data     (w_wr_data),
        .o_frame       (w_frame)
    );

    spf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_SAMPLES)
    ) u_ext_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    spf_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (w_frame),
        .o_done      (w_done),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data),
        .o_push      (w_push),
        .o_res       (w_res),
        .i_res_ready (w_q_ready)
    );

    spf_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_res       (w_res),
        .o_ready     (w_q_ready),
        .o_valid     (o_out_valid),
        .o_res       (w_out),
        .i_pop_ready (i_out_ready)
    );

    assign o_peak_index  = w_out.index;
    assign o_peak_valid  = w_out.valid;
    assign o_last_result = w_out.last;

    // The input closes only after the last sample of a frame has been taken.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(i_in_valid && i_last))
        else $error("input closed without a frame-ending transaction");

    // The walker finishes only a frame that the loader has handed over.
    a_done_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> w_frame.valid)
        else $error("walk finished with no frame pending");

    // A frame with no peak reports a single empty result that ends the frame.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_peak_valid) |-> (o_last_result && o_peak_index == '0))
        else $error("empty report malformed");

    // The walker never pushes into a full result queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_q_ready)
        else $error("result queue overflow");

endmodule
`default_nettype wire
